@@ rtl/conv2d_direct_cropped_assert.svh @@
// Assertion macros used by the checker file of the convolution block.
`ifndef CONV2D_DIRECT_CROPPED_ASSERT_SVH
`define CONV2D_DIRECT_CROPPED_ASSERT_SVH

// A word that is offered and not taken stays offered with the same payload.
`define C2D_ASSERT_HOLD(lbl, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(sig))) else $error("word dropped or changed while stalled");

// A condition that must never be seen at a clock edge out of reset.
`define C2D_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

// A condition at one edge forces another at the next edge.
`define C2D_ASSERT_NEXT(lbl, cause, effect) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("expected follow-up condition missing");

`endif

@@ rtl/c2d_pkg.sv @@
package c2d_pkg;

    localparam int MAX_IMAGE_ROWS  = 64;
    localparam int MAX_IMAGE_COLS  = 64;
    localparam int MAX_KERNEL_ROWS = 8;
    localparam int MAX_KERNEL_COLS = 8;
    localparam int SAMPLE_BITS     = 16;

    // Field widths fixed by the interface.
    localparam int FUNC_W     = 2;
    localparam int DIM_W      = 7;
    localparam int KDIM_W     = 4;
    localparam int SPAN_W     = 8;
    localparam int IN_SAMPLE_W = 16;
    localparam int RESULT_BITS = 40;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam int IMG_DEPTH = MAX_IMAGE_ROWS * MAX_IMAGE_COLS;
    localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int KER_DEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
    localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
    localparam int KR_W      = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
    localparam int KC_W      = (MAX_KERNEL_COLS > 1) ? $clog2(MAX_KERNEL_COLS) : 1;
    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam int ACC_BITS  = PROD_BITS + $clog2(KER_DEPTH) + 1;
    localparam int SAT_W     = (ACC_BITS > RESULT_BITS) ? ACC_BITS : RESULT_BITS;

    localparam logic [FUNC_W-1:0] FN_IMAGE  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_KERNEL = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] SHAPE_FULL  = 2'd0;
    localparam logic [1:0] SHAPE_SAME  = 2'd1;
    localparam logic [1:0] SHAPE_VALID = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SHAPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ICOLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KROWS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KCOLS = 3'd5;

    // Configuration with the sizes already limited to the store bounds.
    typedef struct packed {
        logic [1:0]        shape;
        logic              corr;
        logic [DIM_W-1:0]  m;
        logic [DIM_W-1:0]  n;
        logic [KDIM_W-1:0] p;
        logic [KDIM_W-1:0] q;
    } c2d_cfg_t;

    typedef struct packed {
        logic accept;
        logic check;
        logic step;
        logic load_out;
    } c2d_cmd_t;

    typedef struct packed {
        logic is_read;
        logic chk_ok;
        logic last_tap;
        logic pipe_busy;
        logic out_full;
    } c2d_stat_t;

endpackage

@@ rtl/c2d_cfg.sv @@
module c2d_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]    cfg_data,
    output c2d_pkg::c2d_cfg_t                 cfg
);

    logic [1:0]                      shape_reg;
    logic                            corr_reg;
    logic [c2d_pkg::DIM_W-1:0]       irows_reg;
    logic [c2d_pkg::DIM_W-1:0]       icols_reg;
    logic [c2d_pkg::KDIM_W-1:0]      krows_reg;
    logic [c2d_pkg::KDIM_W-1:0]      kcols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg <= c2d_pkg::SHAPE_FULL;
            corr_reg  <= 1'b0;
            irows_reg <= c2d_pkg::DIM_W'(64);
            icols_reg <= c2d_pkg::DIM_W'(64);
            krows_reg <= c2d_pkg::KDIM_W'(3);
            kcols_reg <= c2d_pkg::KDIM_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                c2d_pkg::REG_SHAPE: shape_reg <= cfg_data[1:0];
                c2d_pkg::REG_CORR:  corr_reg  <= cfg_data[0];
                c2d_pkg::REG_IROWS: irows_reg <= cfg_data[c2d_pkg::DIM_W-1:0];
                c2d_pkg::REG_ICOLS: icols_reg <= cfg_data[c2d_pkg::DIM_W-1:0];
                c2d_pkg::REG_KROWS: krows_reg <= cfg_data[c2d_pkg::KDIM_W-1:0];
                c2d_pkg::REG_KCOLS: kcols_reg <= cfg_data[c2d_pkg::KDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Sizes above the store bounds act as the bound itself.
    always_comb
    begin
        cfg.shape = shape_reg;
        cfg.corr  = corr_reg;
        cfg.m = (int'(irows_reg) > c2d_pkg::MAX_IMAGE_ROWS) ?
                c2d_pkg::DIM_W'(c2d_pkg::MAX_IMAGE_ROWS) : irows_reg;
        cfg.n = (int'(icols_reg) > c2d_pkg::MAX_IMAGE_COLS) ?
                c2d_pkg::DIM_W'(c2d_pkg::MAX_IMAGE_COLS) : icols_reg;
        cfg.p = (int'(krows_reg) > c2d_pkg::MAX_KERNEL_ROWS) ?
                c2d_pkg::KDIM_W'(c2d_pkg::MAX_KERNEL_ROWS) : krows_reg;
        cfg.q = (int'(kcols_reg) > c2d_pkg::MAX_KERNEL_COLS) ?
                c2d_pkg::KDIM_W'(c2d_pkg::MAX_KERNEL_COLS) : kcols_reg;
    end

endmodule

@@ rtl/c2d_ctrl.sv @@
module c2d_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  c2d_pkg::c2d_stat_t  st,
    output c2d_pkg::c2d_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.check    = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = st.is_read ? S_CHECK : S_DONE;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = st.chk_ok ? S_RUN : S_DONE;
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (st.last_tap)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // Wait for the last taps to pass the multiply and the add.
                if (!st.pipe_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!st.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/c2d_dp.sv @@
module c2d_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  c2d_pkg::c2d_cfg_t                       cfg,
    input  c2d_pkg::c2d_cmd_t                       cmd,
    output c2d_pkg::c2d_stat_t                      st,
    input  logic [c2d_pkg::FUNC_W-1:0]              func,
    input  logic [c2d_pkg::DIM_W-1:0]               row,
    input  logic [c2d_pkg::DIM_W-1:0]               col,
    input  logic signed [c2d_pkg::IN_SAMPLE_W-1:0]  sample,
    input  logic                                    out_ready,
    output logic                                    out_valid,
    output logic signed [c2d_pkg::RESULT_BITS-1:0]  result,
    output logic [c2d_pkg::STAT_W-1:0]              status
);

    localparam int SW = c2d_pkg::SPAN_W;
    localparam logic signed [c2d_pkg::SAT_W-1:0] RMAX =
        {{(c2d_pkg::SAT_W - c2d_pkg::RESULT_BITS + 1){1'b0}},
         {(c2d_pkg::RESULT_BITS - 1){1'b1}}};
    localparam logic signed [c2d_pkg::SAT_W-1:0] RMIN = ~RMAX;

    logic signed [c2d_pkg::SAMPLE_BITS-1:0] image_mem [c2d_pkg::IMG_DEPTH];
    logic signed [c2d_pkg::SAMPLE_BITS-1:0] kernel_mem [c2d_pkg::KER_DEPTH];

    logic signed [c2d_pkg::SAMPLE_BITS-1:0] smp;
    logic                                   img_in;
    logic                                   ker_in;
    logic                                   img_we;
    logic                                   ker_we;
    logic [c2d_pkg::IMG_AW-1:0]             img_waddr;
    logic [c2d_pkg::KER_AW-1:0]             ker_waddr;
    logic [c2d_pkg::STAT_W-1:0]             ld_status;

    logic                                   is_read_reg;
    logic [c2d_pkg::DIM_W-1:0]              row_reg;
    logic [c2d_pkg::DIM_W-1:0]              col_reg;
    logic [c2d_pkg::STAT_W-1:0]             stat_reg;

    logic                                   empty;
    logic [SW-1:0]                          out_r;
    logic [SW-1:0]                          out_c;
    logic [c2d_pkg::KDIM_W-1:0]             r0;
    logic [c2d_pkg::KDIM_W-1:0]             c0;
    logic [c2d_pkg::STAT_W-1:0]             chk_status;

    logic [SW-1:0]                          fr_reg;
    logic [SW-1:0]                          fc_reg;
    logic [c2d_pkg::KR_W-1:0]               ti_reg;
    logic [c2d_pkg::KC_W-1:0]               tj_reg;
    logic [c2d_pkg::KR_W-1:0]               ti_last;
    logic [c2d_pkg::KC_W-1:0]               tj_last;
    logic [SW:0]                            ir;
    logic [SW:0]                            ic;
    logic                                   tap_v;
    logic [c2d_pkg::KR_W-1:0]               ki;
    logic [c2d_pkg::KC_W-1:0]               kj;
    logic [c2d_pkg::IMG_AW-1:0]             img_raddr;
    logic [c2d_pkg::KER_AW-1:0]             ker_raddr;

    logic signed [c2d_pkg::SAMPLE_BITS-1:0] img_q_reg;
    logic signed [c2d_pkg::SAMPLE_BITS-1:0] ker_q_reg;
    logic                                   v1_reg;
    logic                                   v2_reg;
    logic signed [c2d_pkg::PROD_BITS-1:0]   prod_reg;
    logic signed [c2d_pkg::ACC_BITS-1:0]    acc_reg;
    logic signed [c2d_pkg::SAT_W-1:0]       acc_wide;
    logic signed [c2d_pkg::SAT_W-1:0]       acc_sat;

    logic                                   out_valid_reg;
    logic signed [c2d_pkg::RESULT_BITS-1:0] result_reg;
    logic [c2d_pkg::STAT_W-1:0]             status_reg;

    // Only the low sample bits are stored; the port carries no more.
    assign smp    = c2d_pkg::SAMPLE_BITS'($unsigned(sample));
    assign img_in = (int'(row) < c2d_pkg::MAX_IMAGE_ROWS) &&
                    (int'(col) < c2d_pkg::MAX_IMAGE_COLS);
    assign ker_in = (int'(row) < c2d_pkg::MAX_KERNEL_ROWS) &&
                    (int'(col) < c2d_pkg::MAX_KERNEL_COLS);
    assign img_we = cmd.accept && (func == c2d_pkg::FN_IMAGE) && img_in;
    assign ker_we = cmd.accept && (func == c2d_pkg::FN_KERNEL) && ker_in;
    assign img_waddr = c2d_pkg::IMG_AW'(row) * c2d_pkg::IMG_AW'(c2d_pkg::MAX_IMAGE_COLS)
                     + c2d_pkg::IMG_AW'(col);
    assign ker_waddr = c2d_pkg::KER_AW'(row) * c2d_pkg::KER_AW'(c2d_pkg::MAX_KERNEL_COLS)
                     + c2d_pkg::KER_AW'(col);

    always_comb
    begin
        case (func)
            c2d_pkg::FN_IMAGE:  ld_status = img_in ? c2d_pkg::ST_OK : c2d_pkg::ST_RANGE;
            c2d_pkg::FN_KERNEL: ld_status = ker_in ? c2d_pkg::ST_OK : c2d_pkg::ST_RANGE;
            default:            ld_status = c2d_pkg::ST_RANGE;
        endcase
    end

    // Output shape, crop offsets and check status of the read point.
    always_comb
    begin
        case (cfg.shape)
            c2d_pkg::SHAPE_SAME:
            begin
                out_r = SW'(cfg.m);
                out_c = SW'(cfg.n);
                r0    = cfg.p >> 1;
                c0    = cfg.q >> 1;
            end
            c2d_pkg::SHAPE_VALID:
            begin
                out_r = (cfg.m >= cfg.p) ? SW'(cfg.m) - SW'(cfg.p) + SW'(1) : '0;
                out_c = (cfg.n >= cfg.q) ? SW'(cfg.n) - SW'(cfg.q) + SW'(1) : '0;
                r0    = cfg.p - c2d_pkg::KDIM_W'(1);
                c0    = cfg.q - c2d_pkg::KDIM_W'(1);
            end
            default:
            begin
                out_r = SW'(cfg.m) + SW'(cfg.p) - SW'(1);
                out_c = SW'(cfg.n) + SW'(cfg.q) - SW'(1);
                r0    = '0;
                c0    = '0;
            end
        endcase
        empty = (cfg.m == '0) || (cfg.n == '0) || (cfg.p == '0) || (cfg.q == '0) ||
                (out_r == '0) || (out_c == '0);
        if (empty)
        begin
            chk_status = c2d_pkg::ST_EMPTY;
        end
        else if ((SW'(row_reg) >= out_r) || (SW'(col_reg) >= out_c))
        begin
            chk_status = c2d_pkg::ST_RANGE;
        end
        else
        begin
            chk_status = c2d_pkg::ST_OK;
        end
    end

    // Tap address generation: taps that fall off the image add zero.
    always_comb
    begin
        ti_last = c2d_pkg::KR_W'(cfg.p - c2d_pkg::KDIM_W'(1));
        tj_last = c2d_pkg::KC_W'(cfg.q - c2d_pkg::KDIM_W'(1));
        ir = {1'b0, fr_reg} - (SW + 1)'(ti_reg);
        ic = {1'b0, fc_reg} - (SW + 1)'(tj_reg);
        tap_v = cmd.step && !ir[SW] && !ic[SW] &&
                (ir[SW-1:0] < SW'(cfg.m)) && (ic[SW-1:0] < SW'(cfg.n));
        ki = cfg.corr ? c2d_pkg::KR_W'(cfg.p - c2d_pkg::KDIM_W'(1)
                                       - c2d_pkg::KDIM_W'(ti_reg)) : ti_reg;
        kj = cfg.corr ? c2d_pkg::KC_W'(cfg.q - c2d_pkg::KDIM_W'(1)
                                       - c2d_pkg::KDIM_W'(tj_reg)) : tj_reg;
        if (tap_v)
        begin
            img_raddr = c2d_pkg::IMG_AW'(ir[SW-1:0])
                      * c2d_pkg::IMG_AW'(c2d_pkg::MAX_IMAGE_COLS)
                      + c2d_pkg::IMG_AW'(ic[SW-1:0]);
            ker_raddr = c2d_pkg::KER_AW'(ki) * c2d_pkg::KER_AW'(c2d_pkg::MAX_KERNEL_COLS)
                      + c2d_pkg::KER_AW'(kj);
        end
        else
        begin
            img_raddr = '0;
            ker_raddr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            image_mem[img_waddr] <= smp;
        end
        img_q_reg <= image_mem[img_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ker_we)
        begin
            kernel_mem[ker_waddr] <= smp;
        end
        ker_q_reg <= kernel_mem[ker_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            is_read_reg <= (func == c2d_pkg::FN_READ);
            row_reg     <= row;
            col_reg     <= col;
            stat_reg    <= ld_status;
        end
        else if (cmd.check)
        begin
            stat_reg <= chk_status;
        end
        if (cmd.check)
        begin
            fr_reg <= SW'(row_reg) + SW'(r0);
            fc_reg <= SW'(col_reg) + SW'(c0);
            ti_reg <= '0;
            tj_reg <= '0;
        end
        else if (cmd.step)
        begin
            if (ti_reg == ti_last)
            begin
                ti_reg <= '0;
                tj_reg <= tj_reg + c2d_pkg::KC_W'(1);
            end
            else
            begin
                ti_reg <= ti_reg + c2d_pkg::KR_W'(1);
            end
        end
        // The product stays a signed multiply on its own, apart from the zero.
        if (v1_reg)
        begin
            prod_reg <= img_q_reg * ker_q_reg;
        end
        else
        begin
            prod_reg <= '0;
        end
        if (cmd.check)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + c2d_pkg::ACC_BITS'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= tap_v;
            v2_reg <= v1_reg;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        acc_wide = c2d_pkg::SAT_W'(acc_reg);
        if (acc_wide > RMAX)
        begin
            acc_sat = RMAX;
        end
        else if (acc_wide < RMIN)
        begin
            acc_sat = RMIN;
        end
        else
        begin
            acc_sat = acc_wide;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg <= (is_read_reg && (stat_reg == c2d_pkg::ST_OK)) ?
                          c2d_pkg::RESULT_BITS'(acc_sat) : '0;
            status_reg <= stat_reg;
        end
    end

    assign st.is_read   = (func == c2d_pkg::FN_READ);
    assign st.chk_ok    = (chk_status == c2d_pkg::ST_OK);
    assign st.last_tap  = (ti_reg == ti_last) && (tj_reg == tj_last);
    assign st.pipe_busy = v1_reg || v2_reg;
    assign st.out_full  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign status    = status_reg;

endmodule

@@ rtl/conv2d_direct_cropped.sv @@
// Channel   Handshake              Payload
// input     in_valid / in_ready    func, row, col, sample
// output    out_valid / out_ready  result, status
// config    cfg_we                 cfg_index, cfg_data
//
// A load word goes from accept to the output state; a read inside the output
// is checked and drained, one kernel tap per cycle through the single
// multiply-accumulate; an empty or out-of-range read skips taps and drain.
// Reset clears control and configuration only; both stores are not cleared.
// A stalled output holds its word while the next input word is taken and
// worked on; that word waits for the output register before it is shown.
module conv2d_direct_cropped (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [c2d_pkg::FUNC_W-1:0]              func,
    input  logic [c2d_pkg::DIM_W-1:0]               row,
    input  logic [c2d_pkg::DIM_W-1:0]               col,
    input  logic signed [c2d_pkg::IN_SAMPLE_W-1:0]  sample,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [c2d_pkg::RESULT_BITS-1:0]  result,
    output logic [c2d_pkg::STAT_W-1:0]              status,
    input  logic                                    cfg_we,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]          cfg_data
);

    c2d_pkg::c2d_cfg_t  cfg;
    c2d_pkg::c2d_cmd_t  cmd;
    c2d_pkg::c2d_stat_t st;

    c2d_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    c2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    c2d_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .st        (st),
        .func      (func),
        .row       (row),
        .col       (col),
        .sample    (sample),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .result    (result),
        .status    (status)
    );

endmodule

@@ rtl/c2d_check.sv @@
`include "conv2d_direct_cropped_assert.svh"

module c2d_check (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [c2d_pkg::RESULT_BITS-1:0]  result,
    input  logic [c2d_pkg::STAT_W-1:0]              status
);

    `C2D_ASSERT_HOLD(a_out_hold, out_valid, out_ready, {result, status})

    // Only a good read carries a value; every flagged word reads zero.
    `C2D_ASSERT_NEVER(a_flag_zero, out_valid && (status != c2d_pkg::ST_OK) && (result != '0))

    // One word is worked on at a time, so a taken word closes the input.
    `C2D_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind conv2d_direct_cropped c2d_check u_c2d_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .status    (status)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import c2d_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [FUNC_W-1:0] FN_SPARE    = 2'd3;
    localparam logic [1:0]        SHAPE_SPARE = 2'd3;
    localparam longint SUM_MAX = (64'sd1 <<< (RESULT_BITS - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct packed {
        logic [FUNC_W-1:0]             fn;
        logic [DIM_W-1:0]              r;
        logic [DIM_W-1:0]              c;
        logic signed [IN_SAMPLE_W-1:0] s;
    } conv_op_t;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0] value;
        logic [STAT_W-1:0]             stat;
    } conv_out_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [FUNC_W-1:0]             func = FN_IMAGE;
    logic [DIM_W-1:0]              row = '0;
    logic [DIM_W-1:0]              col = '0;
    logic signed [IN_SAMPLE_W-1:0] sample = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [RESULT_BITS-1:0] result;
    logic [STAT_W-1:0]             status;
    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = REG_SHAPE;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    conv2d_direct_cropped dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .row       (row),
        .col       (col),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the block: both stores and the size-limited configuration.
    logic signed [IN_SAMPLE_W-1:0] img_mem [IMG_DEPTH];
    logic signed [IN_SAMPLE_W-1:0] ker_mem [KER_DEPTH];
    logic [1:0] shape_sel = SHAPE_FULL;
    logic       corr_on = 1'b0;
    int dim_m = MAX_IMAGE_ROWS;
    int dim_n = MAX_IMAGE_COLS;
    int dim_p = 3;
    int dim_q = 3;

    // Entries already loaded by the words queued so far.
    bit img_set [IMG_DEPTH];
    bit ker_set [KER_DEPTH];

    conv_op_t  op_queue [$];
    conv_out_t results_due [$];
    conv_op_t  taken_op;
    conv_out_t due;

    int queued_count = 0;
    int taken_count = 0;
    int checked_count = 0;
    int fault_count = 0;
    int config_count = 0;
    int n_ok = 0;
    int n_range = 0;
    int n_empty = 0;
    int send_wait = 0;
    int send_calm = 0;
    int take_wait = 0;
    int take_calm = 0;
    int unsigned cycle_count = 0;

    // Returns 1 when the output shape is empty; otherwise gives its size and the
    // offset of its first point inside the full result.
    function automatic bit out_window(output int out_r, output int out_c,
                                      output int r0, output int c0);
        out_r = 0;
        out_c = 0;
        r0 = 0;
        c0 = 0;
        if (dim_m == 0 || dim_n == 0 || dim_p == 0 || dim_q == 0)
            return 1'b1;
        case (shape_sel)
            SHAPE_SAME:
            begin
                out_r = dim_m;
                out_c = dim_n;
                r0 = dim_p / 2;
                c0 = dim_q / 2;
            end
            SHAPE_VALID:
            begin
                out_r = (dim_m >= dim_p) ? dim_m - dim_p + 1 : 0;
                out_c = (dim_n >= dim_q) ? dim_n - dim_q + 1 : 0;
                r0 = dim_p - 1;
                c0 = dim_q - 1;
            end
            default:
            begin
                out_r = dim_m + dim_p - 1;
                out_c = dim_n + dim_q - 1;
            end
        endcase
        return (out_r == 0 || out_c == 0);
    endfunction

    function automatic conv_out_t convolve_point(input int rr, input int cc);
        conv_out_t o;
        int out_r, out_c, r0, c0, fr, fc, i, j, ki, kj;
        longint acc;
        o.value = '0;
        o.stat = ST_OK;
        if (out_window(out_r, out_c, r0, c0))
        begin
            o.stat = ST_EMPTY;
            return o;
        end
        if (rr >= out_r || cc >= out_c)
        begin
            o.stat = ST_RANGE;
            return o;
        end
        fr = rr + r0;
        fc = cc + c0;
        acc = 0;
        for (j = 0; j < dim_q; j++)
        begin
            for (i = 0; i < dim_p; i++)
            begin
                if (fr >= i && fc >= j && fr - i < dim_m && fc - j < dim_n)
                begin
                    ki = corr_on ? dim_p - 1 - i : i;
                    kj = corr_on ? dim_q - 1 - j : j;
                    acc += longint'(img_mem[(fr - i) * MAX_IMAGE_COLS + fc - j])
                         * longint'(ker_mem[ki * MAX_KERNEL_COLS + kj]);
                end
            end
        end
        if (acc > SUM_MAX)
            acc = SUM_MAX;
        if (acc < SUM_MIN)
            acc = SUM_MIN;
        o.value = acc[RESULT_BITS-1:0];
        return o;
    endfunction

    function automatic conv_out_t apply_word(input conv_op_t w);
        conv_out_t o;
        o.value = '0;
        o.stat = ST_OK;
        case (w.fn)
            FN_IMAGE:
            begin
                if (w.r < MAX_IMAGE_ROWS && w.c < MAX_IMAGE_COLS)
                    img_mem[w.r * MAX_IMAGE_COLS + w.c] = w.s;
                else
                    o.stat = ST_RANGE;
            end
            FN_KERNEL:
            begin
                if (w.r < MAX_KERNEL_ROWS && w.c < MAX_KERNEL_COLS)
                    ker_mem[w.r * MAX_KERNEL_COLS + w.c] = w.s;
                else
                    o.stat = ST_RANGE;
            end
            FN_READ:
                o = convolve_point(w.r, w.c);
            default:
                o.stat = ST_RANGE;
        endcase
        return o;
    endfunction

    function automatic logic signed [IN_SAMPLE_W-1:0] rand_sample();
        logic [31:0] raw;
        raw = $urandom;
        case (raw[3:0])
            4'd0: return 16'sh8000;
            4'd1: return 16'sh7fff;
            4'd2: return 16'sh0000;
            4'd3: return 16'shffff;
            default: return raw[31:16];
        endcase
    endfunction

    function automatic int pick_below(input int n);
        return (n > 1) ? $urandom_range(0, n - 1) : 0;
    endfunction

    function automatic int rnd_index();
        return $urandom_range(0, 70);
    endfunction

    // Idle cycles before the next word, with occasional stretches of none.
    function automatic int pick_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic push_op(input logic [FUNC_W-1:0] fn, input int rr, input int cc,
                           input logic signed [IN_SAMPLE_W-1:0] s);
        conv_op_t op;
        op.fn = fn;
        op.r = rr[DIM_W-1:0];
        op.c = cc[DIM_W-1:0];
        op.s = s;
        op_queue.push_back(op);
        queued_count++;
        if (fn == FN_IMAGE && rr < MAX_IMAGE_ROWS && cc < MAX_IMAGE_COLS)
            img_set[rr * MAX_IMAGE_COLS + cc] = 1'b1;
        if (fn == FN_KERNEL && rr < MAX_KERNEL_ROWS && cc < MAX_KERNEL_COLS)
            ker_set[rr * MAX_KERNEL_COLS + cc] = 1'b1;
    endtask

    // A read is preceded by loads of every store entry it touches that was
    // never written, so no read ever depends on undefined store contents.
    task automatic push_read(input int rr, input int cc);
        int out_r, out_c, r0, c0, fr, fc, i, j, ki, kj;
        if (!out_window(out_r, out_c, r0, c0) && rr < out_r && cc < out_c)
        begin
            fr = rr + r0;
            fc = cc + c0;
            for (j = 0; j < dim_q; j++)
            begin
                for (i = 0; i < dim_p; i++)
                begin
                    if (fr >= i && fc >= j && fr - i < dim_m && fc - j < dim_n)
                    begin
                        ki = corr_on ? dim_p - 1 - i : i;
                        kj = corr_on ? dim_q - 1 - j : j;
                        if (!img_set[(fr - i) * MAX_IMAGE_COLS + fc - j])
                            push_op(FN_IMAGE, fr - i, fc - j, rand_sample());
                        if (!ker_set[ki * MAX_KERNEL_COLS + kj])
                            push_op(FN_KERNEL, ki, kj, rand_sample());
                    end
                end
            end
        end
        push_op(FN_READ, rr, cc, rand_sample());
    endtask

    task automatic drain_results();
        while (checked_count != queued_count)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
    endtask

    task automatic write_config(input int shp, input int cor, input int m, input int n,
                                input int p, input int q);
        drain_results();
        write_reg(REG_SHAPE, shp);
        write_reg(REG_CORR, cor);
        write_reg(REG_IROWS, m);
        write_reg(REG_ICOLS, n);
        write_reg(REG_KROWS, p);
        write_reg(REG_KCOLS, q);
        @(posedge clk);
        cfg_we <= 1'b0;
        // Sizes beyond the stores behave as the store bound.
        shape_sel = shp[1:0];
        corr_on = cor[0];
        dim_m = ((m & 127) > MAX_IMAGE_ROWS) ? MAX_IMAGE_ROWS : (m & 127);
        dim_n = ((n & 127) > MAX_IMAGE_COLS) ? MAX_IMAGE_COLS : (n & 127);
        dim_p = ((p & 15) > MAX_KERNEL_ROWS) ? MAX_KERNEL_ROWS : (p & 15);
        dim_q = ((q & 15) > MAX_KERNEL_COLS) ? MAX_KERNEL_COLS : (q & 15);
        config_count++;
    endtask

    // Mostly loads inside the sizes in use and reads inside the output, kept
    // within span of a corner so that large images need few loads.
    task automatic random_ops(input int count, input int span);
        int k, pick, out_r, out_c, r0, c0, lo_r, lo_c;
        bit empty;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            empty = out_window(out_r, out_c, r0, c0);
            if (pick < 2)
                push_op(FN_SPARE, rnd_index(), rnd_index(), rand_sample());
            else if (pick < 32)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_op(FN_IMAGE, rnd_index(), rnd_index(), rand_sample());
                else
                    push_op(FN_IMAGE, pick_below(dim_m), pick_below(dim_n), rand_sample());
            end
            else if (pick < 47)
            begin
                if ($urandom_range(0, 6) == 0)
                    push_op(FN_KERNEL, rnd_index(), rnd_index(), rand_sample());
                else
                    push_op(FN_KERNEL, pick_below(dim_p), pick_below(dim_q), rand_sample());
            end
            else if (!empty && $urandom_range(0, 4) != 0)
            begin
                lo_r = ($urandom_range(0, 1) == 1 && out_r > span) ? out_r - span : 0;
                lo_c = ($urandom_range(0, 1) == 1 && out_c > span) ? out_c - span : 0;
                push_read(lo_r + pick_below(out_r < span ? out_r : span),
                          lo_c + pick_below(out_c < span ? out_c : span));
            end
            else
                push_read(rnd_index(), rnd_index());
        end
    endtask

    // Driver: one word offered at a time, held until taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= FN_IMAGE;
            row <= '0;
            col <= '0;
            sample <= '0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                taken_op.fn = func;
                taken_op.r = row;
                taken_op.c = col;
                taken_op.s = sample;
                results_due.push_back(apply_word(taken_op));
                taken_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (op_queue.size() != 0)
                begin
                    taken_op = op_queue.pop_front();
                    in_valid <= 1'b1;
                    func <= taken_op.fn;
                    row <= taken_op.r;
                    col <= taken_op.c;
                    sample <= taken_op.s;
                    send_wait = pick_wait(send_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result word with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            take_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result word: result %0d status %0d", result, status);
                    fault_count++;
                end
                else
                begin
                    due = results_due.pop_front();
                    if (result !== due.value)
                    begin
                        $error("result: expected %0d, got %0d", due.value, result);
                        fault_count++;
                    end
                    if (status !== due.stat)
                    begin
                        $error("status: expected %0d, got %0d", due.stat, status);
                        fault_count++;
                    end
                    case (due.stat)
                        ST_OK: n_ok++;
                        ST_RANGE: n_range++;
                        default: n_empty++;
                    endcase
                    checked_count++;
                end
                take_wait = pick_wait(take_calm);
            end
            if (take_wait > 0)
            begin
                take_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[conv2d_direct_cropped] ERROR");
            $finish;
        end
    end

    initial
    begin
        int k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: full shape, 64 x 64 image, 3 x 3 kernel.
        push_op(FN_IMAGE, 0, 0, 16'sh8000);
        push_op(FN_IMAGE, 0, 1, 16'sh7fff);
        push_op(FN_IMAGE, 1, 0, 16'shffff);
        push_op(FN_IMAGE, 63, 63, 16'sh7fff);
        push_op(FN_IMAGE, 64, 5, rand_sample());
        push_op(FN_IMAGE, 3, 70, rand_sample());
        push_op(FN_KERNEL, 0, 0, 16'sh7fff);
        push_op(FN_KERNEL, 7, 7, 16'sh8000);
        push_op(FN_KERNEL, 8, 0, rand_sample());
        push_op(FN_KERNEL, 2, 70, rand_sample());
        push_op(FN_SPARE, 70, 70, 16'shffff);
        push_read(0, 0);
        push_read(1, 1);
        push_read(65, 65);
        push_read(66, 3);
        push_read(4, 70);

        // Empty outputs: a zero size, and a kernel larger than the image.
        write_config(SHAPE_FULL, 0, 0, 5, 3, 3);
        push_read(0, 0);
        write_config(SHAPE_SAME, 0, 5, 5, 0, 2);
        push_read(1, 1);
        write_config(SHAPE_VALID, 0, 4, 4, 5, 3);
        push_read(0, 0);
        write_config(SHAPE_VALID, 1, 5, 3, 2, 4);
        push_read(0, 0);
        // Sizes past the store bounds and the unused shape code.
        write_config(SHAPE_SPARE, 1, 127, 100, 15, 15);
        push_read(0, 0);
        push_read(70, 70);
        push_read(70, 0);

        write_config(SHAPE_FULL, 0, 6, 7, 3, 3);
        random_ops(90, 10);
        write_config(SHAPE_SAME, 1, 8, 8, 4, 5);
        random_ops(90, 10);
        write_config(SHAPE_VALID, 0, 9, 6, 3, 2);
        random_ops(80, 10);
        write_config(SHAPE_VALID, 1, 8, 8, 8, 8);
        random_ops(50, 10);
        write_config(SHAPE_SAME, 0, 64, 64, 3, 3);
        random_ops(40, 4);
        write_config(SHAPE_FULL, 1, 1, 1, 1, 1);
        random_ops(30, 4);
        write_config(SHAPE_SPARE, 0, 5, 5, 2, 2);
        random_ops(50, 8);
        write_config(SHAPE_FULL, 0, 64, 1, 8, 1);
        random_ops(50, 8);
        write_config(SHAPE_SAME, 1, 7, 5, 1, 8);
        random_ops(60, 10);
        for (k = 0; k < 4; k++)
        begin
            write_config($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 12),
                         $urandom_range(0, 12), $urandom_range(0, 9), $urandom_range(0, 9));
            random_ops(40, 12);
        end

        drain_results();
        repeat (80) @(posedge clk);
        if (results_due.size() != 0)
        begin
            $error("%0d predicted results never arrived", results_due.size());
            fault_count++;
        end
        $display("%0d words over %0d configurations; reads and loads gave %0d ok,",
                 taken_count, config_count + 1, n_ok);
        $display("%0d out of range and %0d empty results", n_range, n_empty);
        if (fault_count == 0)
            $display("[conv2d_direct_cropped] OK");
        else
            $display("[conv2d_direct_cropped] ERROR");
        $finish;
    end

endmodule
